// ===== rtl/snfcs_pkg.sv =====
// Shared types and constants for the SPI NOR flash command sequencer.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package snfcs_pkg;

	// Request opcodes on the input channel.
	localparam logic [2:0] OP_SECTOR_ERASE = 3'd0;
	localparam logic [2:0] OP_CHIP_ERASE   = 3'd1;
	localparam logic [2:0] OP_PROGRAM      = 3'd2;
	localparam logic [2:0] OP_READ         = 3'd3;
	localparam logic [2:0] OP_MISO         = 3'd4;

	// Result kinds on the output channel.
	localparam logic [2:0] KIND_OUT  = 3'd0;
	localparam logic [2:0] KIND_IN   = 3'd1;
	localparam logic [2:0] KIND_DATA = 3'd2;
	localparam logic [2:0] KIND_DONE = 3'd3;
	localparam logic [2:0] KIND_REJ  = 3'd4;

	// Sequencer phases.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PROG = 2'd1;
	localparam logic [1:0] PH_READ = 2'd2;
	localparam logic [1:0] PH_POLL = 2'd3;

	// Flash command bytes.
	localparam logic [7:0] CMD_WREN = 8'h06;
	localparam logic [7:0] CMD_SE   = 8'h20;
	localparam logic [7:0] CMD_CE   = 8'hC7;
	localparam logic [7:0] CMD_PP   = 8'h02;
	localparam logic [7:0] CMD_READ = 8'h03;
	localparam logic [7:0] CMD_RDSR = 8'h05;

	localparam int STATUS_BUSY_BIT = 0;
	localparam int MAX_RESULTS     = 8;
	localparam int AFIELD_W        = 24;

	// Segments of a job, sent in ascending bit order.
	localparam int SEG_WREN  = 0;
	localparam int SEG_CMD   = 1;
	localparam int SEG_ADDR  = 2;
	localparam int SEG_DBYTE = 3;
	localparam int SEG_POLL  = 4;
	localparam int SEG_IN    = 5;
	localparam int SEG_DONE  = 6;
	localparam int SEG_REJ   = 7;
	localparam int SEG_W     = 8;

	typedef logic [SEG_W-1:0] seg_mask_t;

	typedef struct packed {
		seg_mask_t             mask;
		logic [7:0]            cmd_byte;
		logic                  cmd_fe;
		logic [AFIELD_W-1:0]   address;
		logic                  addr_fe;
		logic [2:0]            dbyte_kind;
		logic [7:0]            dbyte;
		logic                  dbyte_fe;
		logic                  done_fe;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/snfcs_front.sv =====
// Front end: accepts request words, tracks the run and polling phase, and
// turns each word into one job for the back end. Depends on snfcs_pkg.
`default_nettype none

module snfcs_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [2:0]           opcode,
	input  wire logic [23:0]          address,
	input  wire logic [7:0]           data,
	input  wire logic                 first,
	input  wire logic                 last,
	input  wire logic                 poll_status,
	input  wire logic                 q_full,
	output logic                      q_push,
	output snfcs_pkg::job_t           q_job
);

	logic [1:0] phase_q;
	logic       wait_after_q;
	logic       read_ends_q;
	logic [1:0] phase_d;
	logic       wait_after_d;
	logic       read_ends_d;
	logic       rej;
	logic       fin;
	logic       fin_wait;
	snfcs_pkg::job_t job;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign q_job    = job;

	always_comb begin
		job          = '0;
		phase_d      = phase_q;
		wait_after_d = wait_after_q;
		read_ends_d  = read_ends_q;
		rej          = 1'b0;
		fin          = 1'b0;
		fin_wait     = 1'b0;
		job.address  = address;
		unique case (opcode) inside
			snfcs_pkg::OP_SECTOR_ERASE, snfcs_pkg::OP_CHIP_ERASE: begin
				if (phase_q != snfcs_pkg::PH_IDLE) begin
					rej = 1'b1;
				end else begin
					job.mask[snfcs_pkg::SEG_WREN] = 1'b1;
					job.mask[snfcs_pkg::SEG_CMD]  = 1'b1;
					if (opcode == snfcs_pkg::OP_CHIP_ERASE) begin
						job.cmd_byte = snfcs_pkg::CMD_CE;
						job.cmd_fe   = 1'b1;
					end else begin
						job.cmd_byte = snfcs_pkg::CMD_SE;
						job.mask[snfcs_pkg::SEG_ADDR] = 1'b1;
						job.addr_fe  = 1'b1;
					end
					fin      = 1'b1;
					fin_wait = poll_status;
				end
			end
			snfcs_pkg::OP_PROGRAM: begin
				if (first ? (phase_q != snfcs_pkg::PH_IDLE)
				          : (phase_q != snfcs_pkg::PH_PROG)) begin
					rej = 1'b1;
				end else begin
					if (first) begin
						job.mask[snfcs_pkg::SEG_WREN] = 1'b1;
						job.mask[snfcs_pkg::SEG_CMD]  = 1'b1;
						job.mask[snfcs_pkg::SEG_ADDR] = 1'b1;
						job.cmd_byte = snfcs_pkg::CMD_PP;
					end
					job.mask[snfcs_pkg::SEG_DBYTE] = 1'b1;
					job.dbyte_kind = snfcs_pkg::KIND_OUT;
					job.dbyte      = data;
					job.dbyte_fe   = last;
					if (last) begin
						fin          = 1'b1;
						fin_wait     = first ? poll_status : wait_after_q;
						wait_after_d = 1'b0;
					end else begin
						phase_d = snfcs_pkg::PH_PROG;
						if (first) begin
							wait_after_d = poll_status;
						end
					end
				end
			end
			snfcs_pkg::OP_READ: begin
				if (first ? (phase_q != snfcs_pkg::PH_IDLE)
				          : (phase_q != snfcs_pkg::PH_READ || read_ends_q)) begin
					rej = 1'b1;
				end else begin
					if (first) begin
						job.mask[snfcs_pkg::SEG_CMD]  = 1'b1;
						job.mask[snfcs_pkg::SEG_ADDR] = 1'b1;
						job.cmd_byte = snfcs_pkg::CMD_READ;
						phase_d      = snfcs_pkg::PH_READ;
					end
					job.mask[snfcs_pkg::SEG_IN] = 1'b1;
					read_ends_d = last;
				end
			end
			snfcs_pkg::OP_MISO: begin
				if (phase_q == snfcs_pkg::PH_READ) begin
					job.mask[snfcs_pkg::SEG_DBYTE] = 1'b1;
					job.dbyte_kind = snfcs_pkg::KIND_DATA;
					job.dbyte      = data;
					job.dbyte_fe   = read_ends_q;
					if (read_ends_q) begin
						job.mask[snfcs_pkg::SEG_DONE] = 1'b1;
						phase_d     = snfcs_pkg::PH_IDLE;
						read_ends_d = 1'b0;
					end
				end else if (phase_q == snfcs_pkg::PH_POLL) begin
					if (data[snfcs_pkg::STATUS_BUSY_BIT]) begin
						job.mask[snfcs_pkg::SEG_IN] = 1'b1;
					end else begin
						job.mask[snfcs_pkg::SEG_DONE] = 1'b1;
						job.done_fe = 1'b1;
						phase_d     = snfcs_pkg::PH_IDLE;
					end
				end else begin
					rej = 1'b1;
				end
			end
			default: begin
				rej = 1'b1;
			end
		endcase

		// Finishing an operation either starts a status poll or reports done.
		if (fin) begin
			if (fin_wait) begin
				job.mask[snfcs_pkg::SEG_POLL] = 1'b1;
				job.mask[snfcs_pkg::SEG_IN]   = 1'b1;
				phase_d = snfcs_pkg::PH_POLL;
			end else begin
				job.mask[snfcs_pkg::SEG_DONE] = 1'b1;
				phase_d = snfcs_pkg::PH_IDLE;
			end
		end

		if (rej) begin
			job                          = '0;
			job.mask[snfcs_pkg::SEG_REJ] = 1'b1;
			phase_d                      = phase_q;
			wait_after_d                 = wait_after_q;
			read_ends_d                  = read_ends_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= snfcs_pkg::PH_IDLE;
			wait_after_q <= 1'b0;
			read_ends_q  <= 1'b0;
		end else if (q_push) begin
			phase_q      <= phase_d;
			wait_after_q <= wait_after_d;
			read_ends_q  <= read_ends_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/snfcs_fifo.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on snfcs_pkg for the job type.
`default_nettype none

module snfcs_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire snfcs_pkg::job_t  push_job,
	output logic                  full,
	input  wire logic             pop,
	output logic                  pop_valid,
	output snfcs_pkg::job_t       pop_job
);

	localparam int DEPTH = 2;

	snfcs_pkg::job_t mem_q [DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = (count_q == 2'(DEPTH));
	assign pop_valid = (count_q != 2'd0);
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("job pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/snfcs_back.sv =====
// Back end: expands one job into its SPI byte results, one a cycle unless
// stalled, into a registered output stage. Depends on snfcs_pkg.
`default_nettype none

module snfcs_back #(
	parameter int ADDR_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire snfcs_pkg::job_t  q_job,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [2:0]            kind,
	output logic [7:0]            spi_byte,
	output logic                  frame_end,
	output logic                  last_of_run
);

	localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
	localparam int IDX_W      = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ADDR_BYTES - 1);
	localparam logic [2:0] CNT_LAST = 3'(snfcs_pkg::MAX_RESULTS - 1);

	snfcs_pkg::job_t        job_q;
	snfcs_pkg::seg_mask_t   mask_q;
	snfcs_pkg::seg_mask_t   cur;
	snfcs_pkg::seg_mask_t   step_mask;
	snfcs_pkg::seg_mask_t   next_mask;
	logic [IDX_W-1:0]       idx_q;
	logic [2:0]             cnt_q;
	logic                   busy;
	logic                   adv;
	logic                   final_res;
	logic                   load;
	logic                   out_valid_q;
	logic [2:0]             kind_q;
	logic [7:0]             byte_q;
	logic                   fe_q;
	logic                   lor_q;
	logic [2:0]             r_kind;
	logic [7:0]             r_byte;
	logic                   r_fe;
	logic [ADDR_BYTES*8+snfcs_pkg::AFIELD_W-1:0] addr_ext;
	logic [7:0]             addr_byte;

	assign busy      = |mask_q;
	assign adv       = busy && (!out_valid_q || out_ready);
	assign cur       = mask_q & (~mask_q + snfcs_pkg::seg_mask_t'(1));
	assign addr_ext  = {{(ADDR_BYTES*8){1'b0}}, job_q.address};
	assign addr_byte = addr_ext[{idx_q, 3'b000} +: 8];

	// The address segment stays current until its last byte has gone out.
	assign step_mask = (cur[snfcs_pkg::SEG_ADDR] && idx_q != '0) ? '0 : cur;
	assign next_mask = mask_q & ~step_mask;
	assign final_res = (next_mask == '0) || (cnt_q == CNT_LAST);
	assign load      = q_valid && (!busy || (adv && final_res));
	assign q_pop     = load;

	always_comb begin
		r_kind = snfcs_pkg::KIND_REJ;
		r_byte = 8'h00;
		r_fe   = 1'b0;
		if (cur[snfcs_pkg::SEG_WREN]) begin
			r_kind = snfcs_pkg::KIND_OUT;
			r_byte = snfcs_pkg::CMD_WREN;
			r_fe   = 1'b1;
		end else if (cur[snfcs_pkg::SEG_CMD]) begin
			r_kind = snfcs_pkg::KIND_OUT;
			r_byte = job_q.cmd_byte;
			r_fe   = job_q.cmd_fe;
		end else if (cur[snfcs_pkg::SEG_ADDR]) begin
			r_kind = snfcs_pkg::KIND_OUT;
			r_byte = addr_byte;
			r_fe   = job_q.addr_fe && (idx_q == '0);
		end else if (cur[snfcs_pkg::SEG_DBYTE]) begin
			r_kind = job_q.dbyte_kind;
			r_byte = job_q.dbyte;
			r_fe   = job_q.dbyte_fe;
		end else if (cur[snfcs_pkg::SEG_POLL]) begin
			r_kind = snfcs_pkg::KIND_OUT;
			r_byte = snfcs_pkg::CMD_RDSR;
		end else if (cur[snfcs_pkg::SEG_IN]) begin
			r_kind = snfcs_pkg::KIND_IN;
		end else if (cur[snfcs_pkg::SEG_DONE]) begin
			r_kind = snfcs_pkg::KIND_DONE;
			r_fe   = job_q.done_fe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			idx_q       <= LAST_IDX;
			cnt_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= q_job.mask;
				idx_q  <= LAST_IDX;
				cnt_q  <= 3'd0;
			end else if (adv) begin
				mask_q <= final_res ? '0 : next_mask;
				cnt_q  <= cnt_q + 3'd1;
				if (cur[snfcs_pkg::SEG_ADDR] && idx_q != '0) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= q_job;
		end
		if (adv) begin
			kind_q <= r_kind;
			byte_q <= r_byte;
			fe_q   <= r_fe;
			lor_q  <= final_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign spi_byte    = byte_q;
	assign frame_end   = fe_q;
	assign last_of_run = lor_q;

`ifndef SYNTHESIS
	a_final_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && final_res) |=> (out_valid_q && lor_q))
		else $error("last result of a word not marked");
	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		mask_q[snfcs_pkg::SEG_REJ] |-> $onehot(mask_q))
		else $error("rejected word carries other segments");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (idx_q <= LAST_IDX))
		else $error("address byte index out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/spi_nor_flash_command_sequencer.sv =====
// Top level of the SPI NOR flash command sequencer: front end, job queue, back end.
// Depends on snfcs_pkg, snfcs_front, snfcs_fifo and snfcs_back.
//
//   channel  signals                                        direction
//   in       in_valid/in_ready, opcode, address, data,      into block
//            first, last, poll_status
//   out      out_valid/out_ready, kind, spi_byte,           out of block
//            frame_end, last_of_run
//
// Each input word becomes one job in the same cycle it is accepted; a word is
// taken in every cycle while the two-entry job queue has room.
// The back end sends one result per cycle unless the output stalls; a word yields
// 1 to 8 results; the next job loads as the last result of a job is registered.
// A stalled output holds its register while the front keeps filling the queue.
// Reset clears the phase, the queue and the output stage at once; no sweep.
`default_nettype none

module spi_nor_flash_command_sequencer #(
	parameter int ADDR_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [23:0] address,
	input  wire logic [7:0]  data,
	input  wire logic        first,
	input  wire logic        last,
	input  wire logic        poll_status,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [7:0]       spi_byte,
	output logic             frame_end,
	output logic             last_of_run
);

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	snfcs_pkg::job_t push_job;
	snfcs_pkg::job_t pop_job;

	snfcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.address     (address),
		.data        (data),
		.first       (first),
		.last        (last),
		.poll_status (poll_status),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (push_job)
	);

	snfcs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_job   (pop_job)
	);

	snfcs_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (pop_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.spi_byte    (spi_byte),
		.frame_end   (frame_end),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
